// File: src/brr_pkg.sv
// Shared types and constants for the bilinear RGBA resizer.
package brr_pkg;

  localparam int SrcPixelsDefault = 65536;
  localparam int FracBitsDefault  = 11;

  localparam int CfgW  = 13;
  localparam int CfgAw = 3;

  typedef enum logic [CfgAw-1:0] {
    CFG_SRC_WIDTH   = 3'd0,
    CFG_SRC_HEIGHT  = 3'd1,
    CFG_DEST_WIDTH  = 3'd2,
    CFG_DEST_HEIGHT = 3'd3,
    CFG_ROW_STRIDE  = 3'd4
  } cfg_idx_e;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] load_index;
    logic [31:0] load_pixel;
    logic [11:0] dest_row;
    logic [11:0] dest_col;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic [23:0] out_address;
  } out_t;

endpackage

// File: src/brr_ram.sv
// Generic single-port RAM with a registered read.
module brr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/brr_div.sv
// Restoring divider, one quotient bit per cycle.
module brr_div #(
  parameter int DW = 37,
  parameter int VW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = VW'(trial - {1'b0, div_q});
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/bilinear_resize_rgba32.sv
// Top level of the bilinear RGBA resizer: control, address mapping and blending.
//
// Input channel in_valid_i / in_stall_o carries one item per handshake. A load
// item writes load_pixel into the source image store at load_index, if that
// index lies within the store; it gives no result. A compute item maps the destination pixel
// centre into source coordinates, reads four neighbours from the store and
// blends each byte lane, giving one result on out_valid_o / out_stall_i.
// A compute item's run is set by the two restoring dividers that produce index
// and weight one quotient bit per cycle, followed by four reads through the
// single port of the image store. Only one item is in work at a time: the
// input stalls from acceptance of a compute item until the block is idle again.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the finished item holds in the final stage
// until the output register frees.
// Reset clears control state and loads the register reset values; the image
// store is undefined until written. Configuration is written through
// cfg_we_i / cfg_addr_i / cfg_data_i while the block is idle.
module bilinear_resize_rgba32 #(
  parameter int SRC_PIXELS = brr_pkg::SrcPixelsDefault,
  parameter int FRAC_BITS  = brr_pkg::FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [brr_pkg::CfgAw-1:0] cfg_addr_i,
  input  logic [brr_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  brr_pkg::in_t            in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output brr_pkg::out_t           out_data_o
);

  import brr_pkg::*;

  localparam int AW = $clog2(SRC_PIXELS);
  localparam int BW = (AW > 26) ? AW : 26;
  localparam int DW = 26 + FRAC_BITS;
  localparam int WW = FRAC_BITS + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL   = 12'b000000000010,
    S_DIVS  = 12'b000000000100,
    S_DIVW  = 12'b000000001000,
    S_IDX   = 12'b000000010000,
    S_RD0   = 12'b000000100000,
    S_RD1   = 12'b000001000000,
    S_RD2   = 12'b000010000000,
    S_RD3   = 12'b000100000000,
    S_RD4   = 12'b001000000000,
    S_BLEND = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_e;

  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [WW-1:0] w);
    logic signed [8:0]          diff;
    logic signed [FRAC_BITS+10:0] prod;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = (FRAC_BITS + 11)'(diff) * (FRAC_BITS + 11)'($signed({1'b0, w}));
    return a + 8'(prod >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] lerp_px(logic [31:0] a, logic [31:0] b, logic [WW-1:0] w);
    logic [31:0] res;
    for (int k = 0; k < 4; k++) begin
      res[8*k +: 8] = lerp8(a[8*k +: 8], b[8*k +: 8], w);
    end
    return res;
  endfunction

  function automatic logic [12:0] sat13(logic [12:0] v, logic [12:0] lo);
    if (v < lo) return lo;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  state_e state_q, state_d;

  logic [12:0] src_w_q, src_h_q, dst_w_q, dst_h_q, stride_cfg_q;
  logic [12:0] sw_q, sh_q, dw_q, dh_q, stride_q;
  logic [11:0] row_q, col_q;
  logic signed [26:0] ny_q, nx_q;
  logic [23:0] addr_out_q;
  logic [11:0] ys_q, xs_q;
  logic [WW-1:0] wy_q, wx_q;
  logic [BW-1:0] base0_q, base0;
  logic [31:0] p0_q, p1_q, p2_q, p3_q, top_q, bot_q;
  logic        out_valid_q;
  out_t        out_q;

  logic          in_acc, div_start, div_done_y, div_done_x;
  logic [DW-1:0] quo_y, quo_x;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  logic [25:0]   prod_y, prod_x;
  logic [24:0]   prod_a;
  logic          out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = (state_q == S_DIVS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q      <= 13'd256;
      src_h_q      <= 13'd256;
      dst_w_q      <= 13'd256;
      dst_h_q      <= 13'd256;
      stride_cfg_q <= 13'd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SRC_WIDTH:   src_w_q      <= cfg_data_i;
        CFG_SRC_HEIGHT:  src_h_q      <= cfg_data_i;
        CFG_DEST_WIDTH:  dst_w_q      <= cfg_data_i;
        CFG_DEST_HEIGHT: dst_h_q      <= cfg_data_i;
        CFG_ROW_STRIDE:  stride_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.opcode == OP_COMPUTE) state_d = S_MUL;
      end
      S_MUL:   state_d = S_DIVS;
      S_DIVS:  state_d = S_DIVW;
      S_DIVW: begin
        if (div_done_y) state_d = S_IDX;
      end
      S_IDX:   state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_RD3;
      S_RD3:   state_d = S_RD4;
      S_RD4:   state_d = S_BLEND;
      S_BLEND: state_d = S_FIN;
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // n = (2i+1)*S - D for each axis; the weight comes from (n << FRAC_BITS) / 2D.
  assign prod_y = 26'({row_q, 1'b1}) * 26'(sh_q);
  assign prod_x = 26'({col_q, 1'b1}) * 26'(sw_q);
  assign prod_a = 25'(row_q) * 25'(stride_q);
  assign base0  = BW'(ys_q) * BW'(sw_q) + BW'(xs_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sw_q     <= sat13(src_w_q, 13'd2);
      sh_q     <= sat13(src_h_q, 13'd2);
      dw_q     <= sat13(dst_w_q, 13'd1);
      dh_q     <= sat13(dst_h_q, 13'd1);
      stride_q <= (stride_cfg_q == 13'd0) ? sat13(dst_w_q, 13'd1) : stride_cfg_q;
      row_q    <= in_data_i.dest_row;
      col_q    <= in_data_i.dest_col;
    end
    if (state_q == S_MUL) begin
      ny_q       <= $signed({1'b0, prod_y}) - $signed({14'd0, dh_q});
      nx_q       <= $signed({1'b0, prod_x}) - $signed({14'd0, dw_q});
      addr_out_q <= 24'(prod_a + 25'(col_q));
    end
    if (state_q == S_IDX) begin
      if (ny_q[26]) begin
        ys_q <= '0;
        wy_q <= '0;
      end else if (quo_y[DW-1:FRAC_BITS] >= 26'(sh_q) - 26'd1) begin
        ys_q <= 12'(sh_q - 13'd2);
        wy_q <= WW'(1) << FRAC_BITS;
      end else begin
        ys_q <= quo_y[FRAC_BITS +: 12];
        wy_q <= {1'b0, quo_y[FRAC_BITS-1:0]};
      end
      if (nx_q[26]) begin
        xs_q <= '0;
        wx_q <= '0;
      end else if (quo_x[DW-1:FRAC_BITS] >= 26'(sw_q) - 26'd1) begin
        xs_q <= 12'(sw_q - 13'd2);
        wx_q <= WW'(1) << FRAC_BITS;
      end else begin
        xs_q <= quo_x[FRAC_BITS +: 12];
        wx_q <= {1'b0, quo_x[FRAC_BITS-1:0]};
      end
    end
    if (state_q == S_RD0) base0_q <= base0;
    if (state_q == S_RD1) p0_q <= ram_rdata;
    if (state_q == S_RD2) p1_q <= ram_rdata;
    if (state_q == S_RD3) p2_q <= ram_rdata;
    if (state_q == S_RD4) p3_q <= ram_rdata;
    if (state_q == S_BLEND) begin
      top_q <= lerp_px(p0_q, p1_q, wx_q);
      bot_q <= lerp_px(p2_q, p3_q, wx_q);
    end
    if (state_q == S_FIN && out_free) begin
      out_q.pixel       <= lerp_px(top_q, bot_q, wy_q);
      out_q.out_address <= addr_out_q;
    end
  end

  // The store port serves loads in idle and the four neighbour reads otherwise.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(in_data_i.load_index);
    case (state_q)
      S_IDLE: begin
        ram_we = in_acc && in_data_i.opcode == OP_LOAD &&
                 (32'(in_data_i.load_index) < SRC_PIXELS);
      end
      S_RD0:   ram_addr = base0[AW-1:0];
      S_RD1:   ram_addr = AW'(base0_q + BW'(1));
      S_RD2:   ram_addr = AW'(base0_q + BW'(sw_q));
      S_RD3:   ram_addr = AW'(base0_q + BW'(sw_q) + BW'(1));
      default: ;
    endcase
  end

  brr_ram #(
    .WIDTH(32),
    .DEPTH(SRC_PIXELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_data_i.load_pixel),
    .rdata_o(ram_rdata)
  );

  brr_div #(.DW(DW), .VW(14)) u_div_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({ny_q[25:0], {FRAC_BITS{1'b0}}}),
    .divisor_i ({dh_q, 1'b0}),
    .done_o    (div_done_y),
    .quotient_o(quo_y)
  );

  brr_div #(.DW(DW), .VW(14)) u_div_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({nx_q[25:0], {FRAC_BITS{1'b0}}}),
    .divisor_i ({dw_q, 1'b0}),
    .done_o    (div_done_x),
    .quotient_o(quo_x)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE)
    else $error("store written outside idle");

  a_div_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_y |-> (state_q == S_DIVW) && div_done_x)
    else $error("dividers out of step");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == OP_COMPUTE) |=> state_q == S_MUL)
    else $error("compute item did not start");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD0 |-> (wx_q <= (WW'(1) << FRAC_BITS)) && (wy_q <= (WW'(1) << FRAC_BITS)))
    else $error("weight out of range");

endmodule
